// ----- hdl/yuvrgb_pkg.sv -----
// Shared types, constants and coefficient table for the YUV to RGB converter.
// No dependencies; every other file of the block imports this package.
package yuvrgb_pkg;

    // fixed-point setup
    localparam int COEFF_FRAC_BITS = 16;
    localparam int FIX_FRAC        = 24;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int OUT_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int BITS_W      = 5;
    localparam int SHIFT_SEL_W = 4;

    localparam logic [BITS_W-1:0] BITS_MIN = 5'd8;
    localparam logic [BITS_W-1:0] BITS_MAX = 5'd16;
    localparam logic [OUT_W-1:0]  OUT_MAX  = '1;

    // half-float fields
    localparam int HALF_MAN_W = 10;
    localparam int HALF_EXP_W = 5;
    localparam logic [HALF_EXP_W-1:0] HALF_EXP_TOP = '1;

    // datapath widths
    localparam int MAG_W  = 40;
    localparam int COEF_W = COEFF_FRAC_BITS + 1;
    localparam int HI_W   = MAG_W - COEFF_FRAC_BITS;
    localparam int LO_W   = COEFF_FRAC_BITS;
    localparam int PHI_W  = HI_W + COEF_W;
    localparam int PLO_W  = LO_W + COEF_W;
    localparam int ACC_W  = (COEFF_FRAC_BITS + 21 > 44) ? COEFF_FRAC_BITS + 21 : 44;
    localparam int PRD_W  = ACC_W - 1;
    localparam int SHF_W  = $clog2(COEFF_FRAC_BITS + 9);

    // queue and pipeline sizing (depth must be a power of two)
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int BACK_STAGES   = 4;
    localparam int MAX_IN_FLIGHT = 1 + FIFO_DEPTH + BACK_STAGES;
    localparam int INFLIGHT_W    = $clog2(MAX_IN_FLIGHT + 1);

    // matrix coefficients, rounded to nearest
    localparam logic [COEF_W-1:0] K_RV =
        COEF_W'(((64'd1400 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] K_GU =
        COEF_W'(((64'd343 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] K_GV =
        COEF_W'(((64'd711 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] K_BU =
        COEF_W'(((64'd1765 << COEFF_FRAC_BITS) + 64'd500) / 64'd1000);

    // chroma products: red from V, green from U and V, blue from U
    localparam int PRD_N  = 4;
    localparam int PRD_RV = 0;
    localparam int PRD_GU = 1;
    localparam int PRD_GV = 2;
    localparam int PRD_BU = 3;
    localparam logic [PRD_N-1:0] PRD_FROM_U = 4'b1010;
    localparam logic [PRD_N-1:0] PRD_FLIP   = 4'b0110;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_FORMAT = 1'b0,
        REG_SAMPLE_BITS  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FMT_INT  = 1'b0,
        FMT_HALF = 1'b1
    } fmt_t;

    typedef enum logic [1:0] {
        HK_FIN,
        HK_PINF,
        HK_NINF,
        HK_NAN
    } half_kind_t;

    // forced channel result for non-finite inputs
    typedef enum logic [1:0] {
        SP_NONE,
        SP_ZERO,
        SP_FULL
    } special_t;

    typedef struct packed {
        fmt_t                   fmt;
        logic [SHIFT_SEL_W-1:0] shift_sel;
        special_t               spec_r;
        special_t               spec_g;
        special_t               spec_b;
    } chan_ctl_t;

    // classified pixel handed from front to back
    typedef struct packed {
        chan_ctl_t        ctl;
        logic [MAG_W-1:0] y_mag;
        logic             y_neg;
        logic [MAG_W-1:0] u_mag;
        logic             u_neg;
        logic [MAG_W-1:0] v_mag;
        logic             v_neg;
    } work_t;

    function automatic logic [COEF_W-1:0] prd_coef(input int idx);
        logic [COEF_W-1:0] k;
        case (idx)
            PRD_RV:  k = K_RV;
            PRD_GU:  k = K_GU;
            PRD_GV:  k = K_GV;
            PRD_BU:  k = K_BU;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ----- hdl/yuvrgb_front.sv -----
// Front part: configuration registers, input transfer and sample classification.
// Decodes half-float patterns or centers integer chroma; uses yuvrgb_pkg.
module yuvrgb_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]    s_luma,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]    s_chroma_blue,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]    s_chroma_red,
    output logic                               out_valid,
    input  logic                               out_ready,
    output yuvrgb_pkg::work_t                  out_item
);
    import yuvrgb_pkg::*;

    typedef struct packed {
        half_kind_t       kind;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } half_t;

    fmt_t              fmt_reg;
    logic [BITS_W-1:0] sample_bits_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    work_t             out_item_reg;
    work_t             out_item_next;

    logic [BITS_W-1:0]   bits_eff;
    logic [SAMPLE_W:0]   mid;
    logic [SAMPLE_W+1:0] u_ctr;
    logic [SAMPLE_W+1:0] v_ctr;
    logic [SAMPLE_W+1:0] u_abs;
    logic [SAMPLE_W+1:0] v_abs;
    half_t               hy;
    half_t               hu;
    half_t               hv;
    logic                take;

    // exact decode of one half-float pattern into magnitude, sign and kind
    function automatic half_t decode_half(input logic [SAMPLE_W-1:0] h);
        half_t                r;
        logic [HALF_EXP_W-1:0] e;
        logic [HALF_MAN_W-1:0] m;
        logic [MAG_W-1:0]      base;
        e      = h[HALF_MAN_W +: HALF_EXP_W];
        m      = h[HALF_MAN_W-1:0];
        base   = MAG_W'({1'b1, m});
        r.neg  = h[SAMPLE_W-1];
        r.kind = HK_FIN;
        r.mag  = '0;
        if (e == HALF_EXP_TOP) begin
            if (m != '0) begin
                r.kind = HK_NAN;
            end else if (h[SAMPLE_W-1]) begin
                r.kind = HK_NINF;
            end else begin
                r.kind = HK_PINF;
            end
        end else if (e == '0) begin
            // subnormal: mantissa is already in units of 2^-24
            r.mag = MAG_W'(m);
        end else begin
            r.mag = base << (e - HALF_EXP_W'(1));
        end
        return r;
    endfunction

    // forced result of one channel from the kinds of its terms
    function automatic special_t chan_spec(
        input half_kind_t k0,
        input half_kind_t k1,
        input logic       f1,
        input half_kind_t k2,
        input logic       f2
    );
        logic     nan;
        logic     pinf;
        logic     ninf;
        special_t sp;
        nan  = (k0 == HK_NAN) || (k1 == HK_NAN) || (k2 == HK_NAN);
        pinf = (k0 == HK_PINF) || (k1 == HK_PINF && !f1) || (k1 == HK_NINF && f1)
            || (k2 == HK_PINF && !f2) || (k2 == HK_NINF && f2);
        ninf = (k0 == HK_NINF) || (k1 == HK_NINF && !f1) || (k1 == HK_PINF && f1)
            || (k2 == HK_NINF && !f2) || (k2 == HK_PINF && f2);
        if (nan || ninf) begin
            sp = SP_ZERO;
        end else if (pinf) begin
            sp = SP_FULL;
        end else begin
            sp = SP_NONE;
        end
        return sp;
    endfunction

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg         <= FMT_INT;
            sample_bits_reg <= BITS_MIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_INPUT_FORMAT: fmt_reg         <= fmt_t'(cfg_wdata[0]);
                REG_SAMPLE_BITS:  sample_bits_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // integer mode: limit sample width and center the chroma
    always_comb begin
        if (sample_bits_reg < BITS_MIN) begin
            bits_eff = BITS_MIN;
        end else if (sample_bits_reg > BITS_MAX) begin
            bits_eff = BITS_MAX;
        end else begin
            bits_eff = sample_bits_reg;
        end
        mid   = (SAMPLE_W+1)'(1) << (bits_eff - BITS_W'(1));
        u_ctr = {2'b00, s_chroma_blue} - {1'b0, mid};
        v_ctr = {2'b00, s_chroma_red} - {1'b0, mid};
        u_abs = u_ctr[SAMPLE_W+1] ? -u_ctr : u_ctr;
        v_abs = v_ctr[SAMPLE_W+1] ? -v_ctr : v_ctr;
    end

    // half-float mode decode
    assign hy = decode_half(s_luma);
    assign hu = decode_half(s_chroma_blue);
    assign hv = decode_half(s_chroma_red);

    // classified item
    always_comb begin
        out_item_next = '0;
        if (fmt_reg == FMT_HALF) begin
            out_item_next.ctl.fmt       = FMT_HALF;
            out_item_next.ctl.shift_sel = '0;
            out_item_next.ctl.spec_r    = chan_spec(hy.kind, hv.kind, 1'b0, HK_FIN, 1'b0);
            out_item_next.ctl.spec_g    = chan_spec(hy.kind, hu.kind, 1'b1, hv.kind, 1'b1);
            out_item_next.ctl.spec_b    = chan_spec(hy.kind, hu.kind, 1'b0, HK_FIN, 1'b0);
            out_item_next.y_mag         = hy.mag;
            out_item_next.y_neg         = hy.neg;
            out_item_next.u_mag         = hu.mag;
            out_item_next.u_neg         = hu.neg;
            out_item_next.v_mag         = hv.mag;
            out_item_next.v_neg         = hv.neg;
        end else begin
            out_item_next.ctl.fmt       = FMT_INT;
            out_item_next.ctl.shift_sel = SHIFT_SEL_W'(bits_eff - BITS_MIN);
            out_item_next.ctl.spec_r    = SP_NONE;
            out_item_next.ctl.spec_g    = SP_NONE;
            out_item_next.ctl.spec_b    = SP_NONE;
            out_item_next.y_mag         = MAG_W'(s_luma);
            out_item_next.y_neg         = 1'b0;
            out_item_next.u_mag         = MAG_W'(u_abs);
            out_item_next.u_neg         = u_ctr[SAMPLE_W+1];
            out_item_next.v_mag         = MAG_W'(v_abs);
            out_item_next.v_neg         = v_ctr[SAMPLE_W+1];
        end
    end

    // input stage register
    assign s_ready        = !out_valid_reg || out_ready;
    assign take           = s_valid && s_ready;
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- hdl/yuvrgb_fifo.sv -----
// Short queue of classified pixels between front and back parts.
// Small register file with count; uses yuvrgb_pkg for the entry type and depth.
module yuvrgb_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  yuvrgb_pkg::work_t wr_item,
    output logic              rd_valid,
    input  logic              rd_ready,
    output yuvrgb_pkg::work_t rd_item
);
    import yuvrgb_pkg::*;

    work_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  push;
    logic                  pop;

    // handshake flags
    assign wr_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    assign count_next = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item = mem_reg[rd_ptr_reg];

endmodule

// ----- hdl/yuvrgb_back.sv -----
// Back part: four-stage matrix pipeline from classified pixel to 8-bit RGB.
// Partial products, term combine, channel sums, clamp and scale; uses yuvrgb_pkg.
module yuvrgb_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  yuvrgb_pkg::work_t            in_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [yuvrgb_pkg::OUT_W-1:0] m_red,
    output logic [yuvrgb_pkg::OUT_W-1:0] m_green,
    output logic [yuvrgb_pkg::OUT_W-1:0] m_blue
);
    import yuvrgb_pkg::*;

    // stage valids and ready chain
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    // stage 1: partial products
    chan_ctl_t                s1_ctl_reg;
    logic signed [ACC_W-1:0]  s1_y_reg;
    logic signed [ACC_W-1:0]  s1_y_next;
    logic [PHI_W-1:0]         s1_hi_reg   [PRD_N];
    logic [PHI_W-1:0]         s1_hi_next  [PRD_N];
    logic [PLO_W-1:0]         s1_lo_reg   [PRD_N];
    logic [PLO_W-1:0]         s1_lo_next  [PRD_N];
    logic [PRD_N-1:0]         s1_neg_reg;
    logic [PRD_N-1:0]         s1_neg_next;

    // stage 2: signed terms
    chan_ctl_t                s2_ctl_reg;
    logic signed [ACC_W-1:0]  s2_y_reg;
    logic signed [ACC_W-1:0]  s2_term_reg  [PRD_N];
    logic signed [ACC_W-1:0]  s2_term_next [PRD_N];

    // stage 3: channel sums
    chan_ctl_t                s3_ctl_reg;
    logic signed [ACC_W-1:0]  s3_r_reg;
    logic signed [ACC_W-1:0]  s3_g_reg;
    logic signed [ACC_W-1:0]  s3_b_reg;

    // stage 4: output register
    logic [OUT_W-1:0]         s4_r_reg;
    logic [OUT_W-1:0]         s4_g_reg;
    logic [OUT_W-1:0]         s4_b_reg;

    // clamp and scale one channel sum to a byte
    function automatic logic [OUT_W-1:0] to_byte(
        input logic signed [ACC_W-1:0]  acc,
        input chan_ctl_t                ctl,
        input special_t                 sp
    );
        logic [ACC_W-1:0]          shifted;
        logic [FIX_FRAC:0]         clip;
        logic [FIX_FRAC+OUT_W:0]   scaled;
        logic signed [ACC_W-1:0]   fix_one;
        logic [OUT_W-1:0]          res;
        fix_one = ACC_W'(1) << FIX_FRAC;
        shifted = $unsigned(acc) >> (SHF_W'(COEFF_FRAC_BITS) + SHF_W'(ctl.shift_sel));
        if (acc[ACC_W-1]) begin
            clip = '0;
        end else if (acc > fix_one) begin
            clip = (FIX_FRAC+1)'(fix_one);
        end else begin
            clip = acc[FIX_FRAC:0];
        end
        // times 255 as times 256 minus one
        scaled = {clip, {OUT_W{1'b0}}} - (FIX_FRAC+OUT_W+1)'(clip);
        if (ctl.fmt == FMT_HALF) begin
            res = scaled[FIX_FRAC+OUT_W-1:FIX_FRAC];
        end else if (acc[ACC_W-1]) begin
            res = '0;
        end else if (shifted > ACC_W'(OUT_MAX)) begin
            res = OUT_MAX;
        end else begin
            res = shifted[OUT_W-1:0];
        end
        case (sp)
            SP_ZERO: res = '0;
            SP_FULL: res = OUT_MAX;
            default: ;
        endcase
        return res;
    endfunction

    // ready chain from the output back
    assign rdy4     = !s4_valid_reg || m_ready;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;
    assign en1      = in_valid && rdy1;
    assign en2      = s1_valid_reg && rdy2;
    assign en3      = s2_valid_reg && rdy3;
    assign en4      = s3_valid_reg && rdy4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (rdy1) s1_valid_reg <= in_valid;
            if (rdy2) s2_valid_reg <= s1_valid_reg;
            if (rdy3) s3_valid_reg <= s2_valid_reg;
            if (rdy4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: split each magnitude into high and low parts, one multiply each
    always_comb begin
        logic [MAG_W-1:0] mag;
        logic [ACC_W-1:0] y_ext;
        for (int p = 0; p < PRD_N; p++) begin
            mag            = PRD_FROM_U[p] ? in_item.u_mag : in_item.v_mag;
            s1_neg_next[p] = (PRD_FROM_U[p] ? in_item.u_neg : in_item.v_neg) ^ PRD_FLIP[p];
            s1_hi_next[p]  = PHI_W'(mag[MAG_W-1:LO_W]) * PHI_W'(prd_coef(p));
            s1_lo_next[p]  = PLO_W'(mag[LO_W-1:0]) * PLO_W'(prd_coef(p));
        end
        if (in_item.ctl.fmt == FMT_HALF) begin
            y_ext = ACC_W'(in_item.y_mag);
        end else begin
            y_ext = ACC_W'(in_item.y_mag) << COEFF_FRAC_BITS;
        end
        s1_y_next = in_item.y_neg ? -$signed(y_ext) : $signed(y_ext);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_ctl_reg <= in_item.ctl;
            s1_y_reg   <= s1_y_next;
            s1_neg_reg <= s1_neg_next;
            for (int p = 0; p < PRD_N; p++) begin
                s1_hi_reg[p] <= s1_hi_next[p];
                s1_lo_reg[p] <= s1_lo_next[p];
            end
        end
    end

    // stage 2: join partial products; half mode truncates the fraction toward zero
    always_comb begin
        logic [PRD_W-1:0] q;
        for (int p = 0; p < PRD_N; p++) begin
            if (s1_ctl_reg.fmt == FMT_HALF) begin
                q = PRD_W'(s1_hi_reg[p]) + PRD_W'(s1_lo_reg[p] >> COEFF_FRAC_BITS);
            end else begin
                q = (PRD_W'(s1_hi_reg[p]) << COEFF_FRAC_BITS) + PRD_W'(s1_lo_reg[p]);
            end
            s2_term_next[p] = s1_neg_reg[p] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_ctl_reg <= s1_ctl_reg;
            s2_y_reg   <= s1_y_reg;
            for (int p = 0; p < PRD_N; p++) begin
                s2_term_reg[p] <= s2_term_next[p];
            end
        end
    end

    // stage 3: channel sums
    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_ctl_reg <= s2_ctl_reg;
            s3_r_reg   <= s2_y_reg + s2_term_reg[PRD_RV];
            s3_g_reg   <= s2_y_reg + s2_term_reg[PRD_GU] + s2_term_reg[PRD_GV];
            s3_b_reg   <= s2_y_reg + s2_term_reg[PRD_BU];
        end
    end

    // stage 4: clamp, scale and hold for the output transfer
    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_r_reg <= to_byte(s3_r_reg, s3_ctl_reg, s3_ctl_reg.spec_r);
            s4_g_reg <= to_byte(s3_g_reg, s3_ctl_reg, s3_ctl_reg.spec_g);
            s4_b_reg <= to_byte(s3_b_reg, s3_ctl_reg, s3_ctl_reg.spec_b);
        end
    end

    assign m_valid = s4_valid_reg;
    assign m_red   = s4_r_reg;
    assign m_green = s4_g_reg;
    assign m_blue  = s4_b_reg;

endmodule

// ----- hdl/yuv_to_rgb_pixel_converter.sv -----
// Top level of the full-range YUV to 8-bit RGB converter.
// Instantiates yuvrgb_front, yuvrgb_fifo and yuvrgb_back; uses yuvrgb_pkg.
//
// Converts one pixel per clock while the output is not stalled; each pixel passes
// through one input register, the four-entry queue and four back-end stages
// (partial products, term combine, channel sums, clamp and scale). Every stage
// takes a new pixel each cycle unless back-pressure from m_ready holds it; the
// chroma products are split into high and low partial products of at most
// 24 by 17 bits so each fits one multiplier per cycle. input_format selects
// unsigned integer samples or half-float bit patterns; sample_bits (8..16,
// values outside clamp to the nearest end) sets the integer sample width.
// Write configuration only while no pixel is in flight.
module yuv_to_rgb_pixel_converter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]    s_luma,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]    s_chroma_blue,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]    s_chroma_red,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [yuvrgb_pkg::OUT_W-1:0]       m_red,
    output logic [yuvrgb_pkg::OUT_W-1:0]       m_green,
    output logic [yuvrgb_pkg::OUT_W-1:0]       m_blue
);
    import yuvrgb_pkg::*;

    logic  fr_valid;
    logic  fr_ready;
    work_t fr_item;
    logic  q_valid;
    logic  q_ready;
    work_t q_item;

    // classify incoming pixels
    yuvrgb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_luma        (s_luma),
        .s_chroma_blue (s_chroma_blue),
        .s_chroma_red  (s_chroma_red),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_item      (fr_item)
    );

    // decouple front from back
    yuvrgb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_item  (fr_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // matrix pipeline
    yuvrgb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_red    (m_red),
        .m_green  (m_green),
        .m_blue   (m_blue)
    );

endmodule

// ----- hdl/yuvrgb_checker.sv -----
// Port-level checker for the YUV to RGB converter, bound to the top level.
// Tracks pixels in flight from the transfers; uses yuvrgb_pkg.
module yuvrgb_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [yuvrgb_pkg::OUT_W-1:0]       m_red,
    input logic [yuvrgb_pkg::OUT_W-1:0]       m_green,
    input logic [yuvrgb_pkg::OUT_W-1:0]       m_blue
);
    import yuvrgb_pkg::*;

    logic [INFLIGHT_W-1:0] in_flight_reg;
    logic [INFLIGHT_W-1:0] in_flight_next;
    logic                  in_xfer;
    logic                  out_xfer;

    // pixels accepted but not yet delivered
    assign in_xfer        = s_valid && s_ready;
    assign out_xfer       = m_valid && m_ready;
    assign in_flight_next = in_flight_reg + INFLIGHT_W'(in_xfer) - INFLIGHT_W'(out_xfer);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_flight_reg <= '0;
        end else begin
            in_flight_reg <= in_flight_next;
        end
    end

    // reset empties the output
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue))
        else $error("stalled result changed");

    // no result without an accepted pixel
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> in_flight_reg != '0)
        else $error("result with no pixel in flight");

    // storage never overfills
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight_reg <= INFLIGHT_W'(MAX_IN_FLIGHT))
        else $error("more pixels in flight than storage");

    // an empty block takes input
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight_reg == '0 |-> s_ready)
        else $error("empty block not ready");

endmodule

bind yuv_to_rgb_pixel_converter yuvrgb_checker u_checker (.*);

// ----- test/tb.sv -----
// Self-checking testbench for yuv_to_rgb_pixel_converter: integer and half-float pixels
// are checked against a bit-exact color matrix predictor under random handshake gaps.
// Depends on yuvrgb_pkg and the converter RTL.
module tb;
    import yuvrgb_pkg::*;

    // fixed-point setup of the predictor
    localparam int     QF      = COEFF_FRAC_BITS;
    localparam int     HALF_FF = FIX_FRAC;
    localparam longint CK_ONE  = longint'(1) << QF;
    localparam longint CK_RV   = ((longint'(1400) << QF) + 500) / 1000;
    localparam longint CK_GU   = ((longint'(343) << QF) + 500) / 1000;
    localparam longint CK_GV   = ((longint'(711) << QF) + 500) / 1000;
    localparam longint CK_BU   = ((longint'(1765) << QF) + 500) / 1000;
    localparam int     STALL_LIMIT = 2000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] u;
        logic [SAMPLE_W-1:0] v;
        logic [OUT_W-1:0]    red;
        logic [OUT_W-1:0]    green;
        logic [OUT_W-1:0]    blue;
    } pixel_rgb_t;

    // running state of one half-float channel sum
    typedef struct packed {
        logic               nan;
        logic               pinf;
        logic               ninf;
        logic signed [63:0] sum;
    } half_sum_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_luma;
    logic [SAMPLE_W-1:0]   s_chroma_blue;
    logic [SAMPLE_W-1:0]   s_chroma_red;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_W-1:0]      m_red;
    logic [OUT_W-1:0]      m_green;
    logic [OUT_W-1:0]      m_blue;

    // local copy of the configuration registers
    fmt_t                  cur_fmt;
    logic [CFG_DATA_W-1:0] cur_bits;

    pixel_rgb_t expected_rgb_q[$];
    int         error_count = 0;
    int         quiet_cycles = 0;
    bit         tx_gaps = 1'b0;
    bit         rx_gaps = 1'b0;

    yuv_to_rgb_pixel_converter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_luma        (s_luma),
        .s_chroma_blue (s_chroma_blue),
        .s_chroma_red  (s_chroma_red),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue)
    );

    // clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int eff_bits();
        int b;
        b = int'(cur_bits);
        if (b < 8) b = 8;
        if (b > 16) b = 16;
        return b;
    endfunction

    // clamp an integer-mode sum to 0..2^B-1 and keep the top eight bits
    function automatic logic [OUT_W-1:0] int_chan(longint sum, int bits);
        longint lim;
        lim = ((longint'(1) << bits) - 1) << QF;
        if (sum < 0) sum = 0;
        if (sum > lim) sum = lim;
        return OUT_W'(sum >> (QF + bits - 8));
    endfunction

    // exact half-float decode into signed fixed point with 24 fraction bits
    function automatic half_kind_t half_decode(input logic [SAMPLE_W-1:0] h,
                                               output longint fix);
        logic [4:0] ex;
        logic [9:0] mn;
        longint     mag;
        ex  = h[14:10];
        mn  = h[9:0];
        fix = 0;
        if (ex == 5'h1f) begin
            if (mn != 10'd0) return HK_NAN;
            if (h[15]) return HK_NINF;
            return HK_PINF;
        end
        if (ex == 5'd0) mag = longint'(mn);
        else mag = (longint'(1024) + longint'(mn)) << (int'(ex) - 1);
        fix = h[15] ? -mag : mag;
        return HK_FIN;
    endfunction

    // fix * k / 2^QF with truncation toward zero, sign flipped by neg
    function automatic longint half_term(longint fix, longint k, bit neg);
        bit     an;
        longint mag, hi, lo, q;
        an  = fix < 0;
        mag = an ? -fix : fix;
        hi  = mag >> QF;
        lo  = mag & ((longint'(1) << QF) - 1);
        q   = hi * k + ((lo * k) >> QF);
        return (an != neg) ? -q : q;
    endfunction

    function automatic half_sum_t half_add(half_sum_t a, half_kind_t kd, longint fix,
                                           longint k, bit neg);
        bit plus;
        plus = (kd == HK_PINF) != neg;
        case (kd) inside
            HK_NAN: begin
                a.nan = 1'b1;
            end
            HK_PINF, HK_NINF: begin
                if (plus) a.pinf = 1'b1;
                else a.ninf = 1'b1;
            end
            default: begin
                a.sum = a.sum + half_term(fix, k, neg);
            end
        endcase
        return a;
    endfunction

    // nan and opposite infinities give zero, one infinity saturates
    function automatic logic [OUT_W-1:0] half_finish(half_sum_t a);
        longint s;
        if (a.nan || (a.pinf && a.ninf)) return '0;
        if (a.pinf) return '1;
        if (a.ninf) return '0;
        s = a.sum;
        if (s < 0) s = 0;
        if (s > (longint'(1) << HALF_FF)) s = longint'(1) << HALF_FF;
        return OUT_W'((s * 255) >> HALF_FF);
    endfunction

    function automatic pixel_rgb_t predict_rgb(logic [SAMPLE_W-1:0] y,
                                               logic [SAMPLE_W-1:0] u,
                                               logic [SAMPLE_W-1:0] v);
        pixel_rgb_t p;
        int         bits;
        longint     mid, ys, us, vs, fy, fu, fv;
        half_kind_t ky, ku, kv;
        half_sum_t  acc;
        p.y = y;
        p.u = u;
        p.v = v;
        if (cur_fmt == FMT_INT) begin
            bits    = eff_bits();
            mid     = longint'(1) << (bits - 1);
            ys      = longint'(y) << QF;
            us      = longint'(u) - mid;
            vs      = longint'(v) - mid;
            p.red   = int_chan(ys + CK_RV * vs, bits);
            p.green = int_chan(ys - CK_GU * us - CK_GV * vs, bits);
            p.blue  = int_chan(ys + CK_BU * us, bits);
        end else begin
            ky = half_decode(y, fy);
            ku = half_decode(u, fu);
            kv = half_decode(v, fv);
            // red: Y + 1.4 V
            acc   = half_add('0, ky, fy, CK_ONE, 1'b0);
            acc   = half_add(acc, kv, fv, CK_RV, 1'b0);
            p.red = half_finish(acc);
            // green: Y - 0.343 U - 0.711 V
            acc     = half_add('0, ky, fy, CK_ONE, 1'b0);
            acc     = half_add(acc, ku, fu, CK_GU, 1'b1);
            acc     = half_add(acc, kv, fv, CK_GV, 1'b1);
            p.green = half_finish(acc);
            // blue: Y + 1.765 U
            acc    = half_add('0, ky, fy, CK_ONE, 1'b0);
            acc    = half_add(acc, ku, fu, CK_BU, 1'b0);
            p.blue = half_finish(acc);
        end
        return p;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic flag_error(string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // register write; starts and ends at a falling edge
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        case (idx)
            REG_INPUT_FORMAT: cur_fmt = fmt_t'(data[0]);
            REG_SAMPLE_BITS:  cur_bits = data;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // one pixel transfer on the input channel, with random gaps ahead of it
    task automatic send_pixel(logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] u,
                              logic [SAMPLE_W-1:0] v);
        while (tx_gaps && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_luma        <= y;
        s_chroma_blue <= u;
        s_chroma_red  <= v;
        do @(posedge aclk); while (!s_ready);
        expected_rgb_q.push_back(predict_rgb(y, u, v));
        @(negedge aclk);
    endtask

    // drop valid and wait for every outstanding pixel to come back
    task automatic drain_pixels();
        s_valid <= 1'b0;
        while (expected_rgb_q.size() != 0) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic logic [SAMPLE_W-1:0] rand_int_sample(bit chroma);
        int hi;
        hi = (1 << eff_bits()) - 1;
        case ($urandom_range(9))
            0: return SAMPLE_W'($urandom);
            1: return $urandom_range(1) ? SAMPLE_W'(hi) : '0;
            2: return chroma ? SAMPLE_W'((hi + 1) / 2) : SAMPLE_W'(hi);
            default: return SAMPLE_W'($urandom_range(hi));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_half_sample(bit chroma);
        logic sgn;
        sgn = chroma ? 1'(($urandom_range(1))) : ($urandom_range(7) == 0);
        case ($urandom_range(11))
            0: return SAMPLE_W'($urandom);
            1: return {sgn, 5'h1f, ($urandom_range(1) ? 10'($urandom) : 10'd0)};
            2: return {sgn, 5'd0, 10'($urandom)};
            3: return {sgn, 15'd0};
            default: return {sgn, 5'($urandom_range(15)), 10'($urandom)};
        endcase
    endfunction

    task automatic send_random_pixel();
        if (cur_fmt == FMT_INT)
            send_pixel(rand_int_sample(1'b0), rand_int_sample(1'b1), rand_int_sample(1'b1));
        else
            send_pixel(rand_half_sample(1'b0), rand_half_sample(1'b1),
                       rand_half_sample(1'b1));
    endtask

    // 8-bit integer pixels at reset settings
    task automatic test_int8_corners();
        send_pixel(16'd0, 16'd128, 16'd128);
        send_pixel(16'd255, 16'd128, 16'd128);
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'd255, 16'd255, 16'd255);
        send_pixel(16'd128, 16'd0, 16'd255);
        // samples above the sample range rely on the channel clamp
        send_pixel(16'hffff, 16'hffff, 16'hffff);
        drain_pixels();
    endtask

    // sample widths, including settings outside 8..16
    task automatic test_sample_widths();
        logic [CFG_DATA_W-1:0] widths[4];
        widths = '{5'd16, 5'd10, 5'd0, 5'd31};
        foreach (widths[i]) begin
            write_reg(REG_SAMPLE_BITS, widths[i]);
            send_pixel(16'hffff, 16'h8000, 16'h0000);
            send_pixel(16'h0000, 16'hffff, 16'h0200);
            drain_pixels();
        end
    endtask

    // half-float corners: zeros, subnormals, max finite, infinities, nan
    task automatic test_half_specials();
        write_reg(REG_INPUT_FORMAT, 5'(FMT_HALF));
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'h3c00, 16'h0000, 16'h0000);
        send_pixel(16'h3800, 16'h3400, 16'hb400);
        send_pixel(16'h0001, 16'h03ff, 16'h8001);
        send_pixel(16'h7bff, 16'hfbff, 16'h7bff);
        send_pixel(16'h7c00, 16'h0000, 16'h0000);
        send_pixel(16'hfc00, 16'h3c00, 16'h3c00);
        send_pixel(16'h3800, 16'h7c00, 16'hfc00);
        send_pixel(16'h7c00, 16'h0000, 16'hfc00);
        send_pixel(16'h7e00, 16'h3800, 16'h3800);
        send_pixel(16'h3800, 16'hffff, 16'h0000);
        drain_pixels();
    endtask

    // random pixels over a series of settings
    task automatic test_random_pixels();
        logic [CFG_DATA_W-1:0] bits;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase % 4)
                0: bits = 5'd8;
                1: bits = 5'd16;
                2: bits = 5'($urandom_range(8, 16));
                default: bits = 5'($urandom_range(31));
            endcase
            write_reg(REG_SAMPLE_BITS, bits);
            write_reg(REG_INPUT_FORMAT, (phase == 0) ? 5'(FMT_INT) : 5'($urandom_range(1)));
            // first phase runs at full rate on both sides
            tx_gaps = (phase != 0);
            rx_gaps = (phase != 0);
            for (int n = 0; n < 50; n++) begin
                // hold off the sender once until the pipeline is empty
                if (phase == 3 && n == 25) drain_pixels();
                send_random_pixel();
            end
            drain_pixels();
        end
    endtask

    // ---------------------------------------------------------------- checking

    // receiver gaps
    always @(negedge aclk) begin
        if (aresetn) m_ready <= rx_gaps ? ($urandom_range(99) >= 28) : 1'b1;
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        pixel_rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rgb_q.size() == 0) begin
                flag_error($sformatf("unexpected pixel rgb %02h %02h %02h",
                                     m_red, m_green, m_blue));
            end else begin
                want = expected_rgb_q.pop_front();
                if (m_red !== want.red)
                    flag_error($sformatf("red got %02h want %02h for yuv %04h %04h %04h",
                                         m_red, want.red, want.y, want.u, want.v));
                if (m_green !== want.green)
                    flag_error($sformatf("green got %02h want %02h for yuv %04h %04h %04h",
                                         m_green, want.green, want.y, want.u, want.v));
                if (m_blue !== want.blue)
                    flag_error($sformatf("blue got %02h want %02h for yuv %04h %04h %04h",
                                         m_blue, want.blue, want.y, want.u, want.v));
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** yuv_to_rgb_pixel_converter: FAILED **");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_INPUT_FORMAT;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_luma        = '0;
        s_chroma_blue = '0;
        s_chroma_red  = '0;
        cur_fmt       = FMT_INT;
        cur_bits      = BITS_MIN;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_int8_corners();
        test_sample_widths();
        test_half_specials();
        test_random_pixels();

        drain_pixels();
        repeat (16) @(negedge aclk);
        if (error_count == 0) begin
            $display("** yuv_to_rgb_pixel_converter: PASSED **");
        end else begin
            $display("** yuv_to_rgb_pixel_converter: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/yuvrgb_pkg.sv
hdl/yuvrgb_front.sv
hdl/yuvrgb_fifo.sv
hdl/yuvrgb_back.sv
hdl/yuv_to_rgb_pixel_converter.sv
hdl/yuvrgb_checker.sv
test/tb.sv
